@@ rtl/csort_pkg.sv @@
// Shared types and constants for the cocktail shaker sorter.
`default_nettype none
package csort_pkg;

  localparam int unsigned POS_W   = 6;
  localparam int unsigned COUNT_W = 11;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_LOAD,
    ST_ROUND,
    ST_F_START,
    ST_FWD,
    ST_F_TAIL,
    ST_B_CHECK,
    ST_B_START,
    ST_BWD,
    ST_B_TAIL,
    ST_R_END,
    ST_O_RD,
    ST_O_LD
  } csort_state_t;

  // Result word load request from the sequencer to the output register
  typedef struct packed {
    logic               load;
    logic [POS_W-1:0]   position;
    logic               last;
    logic [COUNT_W-1:0] compares;
    logic [COUNT_W-1:0] exchanges;
    logic               overflow;
  } csort_out_ld_t;

endpackage
`default_nettype wire

@@ rtl/csort_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module csort_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/csort_seq.sv @@
// Sequencer: loads the element store, runs shaker passes over it, reads it out.
`default_nettype none
module csort_seq
  import csort_pkg::*;
#(
  parameter int unsigned DEPTH       = 64,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // load side
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [VALUE_WIDTH-1:0]   in_value,
  input  wire logic                     in_last,
  // element store
  output logic                          mem_we,
  output logic      [$clog2(DEPTH)-1:0] mem_waddr,
  output logic      [VALUE_WIDTH-1:0]   mem_wdata,
  output logic                          mem_re,
  output logic      [$clog2(DEPTH)-1:0] mem_raddr,
  input  wire logic [VALUE_WIDTH-1:0]   mem_rdata,
  // output register
  input  wire logic                     out_free,
  output csort_out_ld_t                 out_ld
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  csort_state_t state_r, state_nxt;

  logic [CW-1:0]          count_r, count_nxt;
  logic [IW-1:0]          left_r, left_nxt;
  logic [IW-1:0]          right_r, right_nxt;
  logic [IW-1:0]          daddr_r, daddr_nxt;
  logic [IW-1:0]          k_r, k_nxt;
  logic [VALUE_WIDTH-1:0] held_r, held_nxt;
  logic                   first_r, first_nxt;
  logic                   swap_r, swap_nxt;
  logic [COUNT_W-1:0]     cmp_r, cmp_nxt;
  logic [COUNT_W-1:0]     xch_r, xch_nxt;
  logic                   ovf_r, ovf_nxt;

  logic                   room;
  logic [CW-1:0]          n_load;
  logic [CW-1:0]          cnt_m1;
  logic [IW-1:0]          last_idx;
  logic [IW-1:0]          n_load_m1;
  logic                   gt_fwd;
  logic                   gt_bwd;
  logic                   at_final;
  logic [IW+POS_W-1:0]    k_ext;
  logic [COUNT_W-1:0]     cmp_inc;
  logic [COUNT_W-1:0]     xch_inc;

  assign room      = (count_r < FULL);
  assign n_load    = room ? (count_r + 1'b1) : count_r;
  assign n_load_m1 = IW'(n_load - 1'b1);
  assign cnt_m1    = count_r - 1'b1;
  assign last_idx  = cnt_m1[IW-1:0];
  assign gt_fwd    = $signed(held_r) > $signed(mem_rdata);
  assign gt_bwd    = $signed(mem_rdata) > $signed(held_r);
  assign at_final  = (k_r == last_idx);
  assign k_ext     = {{POS_W{1'b0}}, k_r};
  assign cmp_inc   = (cmp_r == COUNT_MAX) ? cmp_r : cmp_r + 1'b1;
  assign xch_inc   = (xch_r == COUNT_MAX) ? xch_r : xch_r + 1'b1;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_valid && in_last) begin
          state_nxt = (n_load == CW'(1)) ? ST_O_RD : ST_ROUND;
        end
      end
      ST_ROUND:   state_nxt = (left_r < right_r) ? ST_F_START : ST_R_END;
      ST_F_START: state_nxt = ST_FWD;
      ST_FWD: begin
        if (!first_r && daddr_r == right_r) begin
          state_nxt = ST_F_TAIL;
        end
      end
      ST_F_TAIL:  state_nxt = ST_B_CHECK;
      ST_B_CHECK: state_nxt = (right_r > left_r) ? ST_B_START : ST_R_END;
      ST_B_START: state_nxt = ST_BWD;
      ST_BWD: begin
        if (!first_r && daddr_r == left_r) begin
          state_nxt = ST_B_TAIL;
        end
      end
      ST_B_TAIL:  state_nxt = ST_R_END;
      ST_R_END:   state_nxt = swap_r ? ST_ROUND : ST_O_RD;
      ST_O_RD: begin
        if (out_free) begin
          state_nxt = ST_O_LD;
        end
      end
      ST_O_LD:    state_nxt = at_final ? ST_LOAD : ST_O_RD;
      default:    state_nxt = ST_LOAD;
    endcase
  end

  // Datapath, memory access and bookkeeping
  always_comb begin
    count_nxt = count_r;
    left_nxt  = left_r;
    right_nxt = right_r;
    daddr_nxt = daddr_r;
    k_nxt     = k_r;
    held_nxt  = held_r;
    first_nxt = first_r;
    swap_nxt  = swap_r;
    cmp_nxt   = cmp_r;
    xch_nxt   = xch_r;
    ovf_nxt   = ovf_r;
    in_ready  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = daddr_r;
    mem_wdata = held_r;
    mem_re    = 1'b0;
    mem_raddr = daddr_r;
    out_ld    = '0;
    unique case (state_r)
      ST_LOAD: begin
        in_ready  = 1'b1;
        mem_waddr = count_r[IW-1:0];
        mem_wdata = in_value;
        if (in_valid) begin
          // store while room is left, otherwise drop and flag
          if (room) begin
            mem_we    = 1'b1;
            count_nxt = count_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last) begin
            left_nxt  = '0;
            right_nxt = n_load_m1;
            k_nxt     = '0;
          end
        end
      end
      ST_ROUND: begin
        swap_nxt = 1'b0;
      end
      ST_F_START: begin
        mem_re    = 1'b1;
        mem_raddr = left_r;
        daddr_nxt = left_r;
        first_nxt = 1'b1;
      end
      ST_FWD: begin
        // read one ahead, settle the pair behind the read data
        mem_re    = 1'b1;
        mem_raddr = (daddr_r == right_r) ? daddr_r : daddr_r + 1'b1;
        daddr_nxt = mem_raddr;
        mem_waddr = daddr_r - 1'b1;
        if (first_r) begin
          held_nxt  = mem_rdata;
          first_nxt = 1'b0;
        end else begin
          cmp_nxt = cmp_inc;
          mem_we  = 1'b1;
          if (gt_fwd) begin
            mem_wdata = mem_rdata;
            xch_nxt   = xch_inc;
            swap_nxt  = 1'b1;
          end else begin
            mem_wdata = held_r;
            held_nxt  = mem_rdata;
          end
        end
      end
      ST_F_TAIL: begin
        // drop the largest value at the right bound and narrow it
        mem_we    = 1'b1;
        mem_waddr = right_r;
        mem_wdata = held_r;
        right_nxt = right_r - 1'b1;
      end
      ST_B_CHECK: begin
      end
      ST_B_START: begin
        mem_re    = 1'b1;
        mem_raddr = right_r;
        daddr_nxt = right_r;
        first_nxt = 1'b1;
      end
      ST_BWD: begin
        mem_re    = 1'b1;
        mem_raddr = (daddr_r == left_r) ? daddr_r : daddr_r - 1'b1;
        daddr_nxt = mem_raddr;
        mem_waddr = daddr_r + 1'b1;
        if (first_r) begin
          held_nxt  = mem_rdata;
          first_nxt = 1'b0;
        end else begin
          cmp_nxt = cmp_inc;
          mem_we  = 1'b1;
          if (gt_bwd) begin
            mem_wdata = mem_rdata;
            xch_nxt   = xch_inc;
            swap_nxt  = 1'b1;
          end else begin
            mem_wdata = held_r;
            held_nxt  = mem_rdata;
          end
        end
      end
      ST_B_TAIL: begin
        mem_we    = 1'b1;
        mem_waddr = left_r;
        mem_wdata = held_r;
      end
      ST_R_END: begin
        left_nxt = left_r + 1'b1;
        k_nxt    = '0;
      end
      ST_O_RD: begin
        mem_raddr = k_r;
        mem_re    = out_free;
      end
      ST_O_LD: begin
        out_ld.load      = 1'b1;
        out_ld.position  = k_ext[POS_W-1:0];
        out_ld.last      = at_final;
        out_ld.compares  = at_final ? cmp_r : '0;
        out_ld.exchanges = at_final ? xch_r : '0;
        out_ld.overflow  = ovf_r;
        k_nxt            = k_r + 1'b1;
        // batch done: clear for the next load
        if (at_final) begin
          count_nxt = '0;
          cmp_nxt   = '0;
          xch_nxt   = '0;
          ovf_nxt   = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      count_r <= '0;
      left_r  <= '0;
      right_r <= '0;
      k_r     <= '0;
      first_r <= 1'b0;
      swap_r  <= 1'b0;
      cmp_r   <= '0;
      xch_r   <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      left_r  <= left_nxt;
      right_r <= right_nxt;
      k_r     <= k_nxt;
      first_r <= first_nxt;
      swap_r  <= swap_nxt;
      cmp_r   <= cmp_nxt;
      xch_r   <= xch_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    daddr_r <= daddr_nxt;
    held_r  <= held_nxt;
  end

endmodule
`default_nettype wire

@@ rtl/cocktail_shaker_sorter_top.sv @@
// Top level of the cocktail shaker sorter: store, sequencer and output register.
//
//   channel | dir | handshake         | payload
//   --------+-----+-------------------+------------------------------------------
//   in_     | in  | in_tvalid/tready  | tdata: value; tlast: is_last
//   out_    | out | out_tvalid/tready | tdata: sorted_value, position, counts,
//           |     |                   |        overflow; tlast: final_item
//
// Loading accepts one word per cycle. After the last word the sort walks the
// element store through its one read port and one write port, running a
// forward and a backward pass per round and narrowing the bounds. Readout
// reads each result from the store, then loads it into the output register.
// Reset clears control state only; the store needs no clearing pass. A stall
// on out_tready holds the result and pauses readout; input is taken only
// while loading.
`default_nettype none
module cocktail_shaker_sorter_top
  import csort_pkg::*;
#(
  parameter int unsigned DEPTH       = 64,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] value
  input  wire logic        in_tlast,   // is_last
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [63:0] out_tdata,  // [31:0] sorted_value, [37:32] position,
                                       // [48:38] compare_count,
                                       // [59:49] exchange_count, [60] overflow
  output logic             out_tlast   // final_item
);

  localparam int unsigned IW = $clog2(DEPTH);

  logic                   mem_we;
  logic [IW-1:0]          mem_waddr;
  logic [VALUE_WIDTH-1:0] mem_wdata;
  logic                   mem_re;
  logic [IW-1:0]          mem_raddr;
  logic [VALUE_WIDTH-1:0] mem_rdata;

  logic [VALUE_WIDTH+31:0] in_ext;
  logic [VALUE_WIDTH+31:0] rd_ext;
  csort_out_ld_t           out_ld;
  logic                    out_free;

  logic               out_valid_r;
  logic [31:0]        out_value_r;
  logic [POS_W-1:0]   out_pos_r;
  logic               out_last_r;
  logic [COUNT_W-1:0] out_cmp_r;
  logic [COUNT_W-1:0] out_xch_r;
  logic               out_ovf_r;

  // Fit the input word to the stored width and the stored word to the port
  assign in_ext = {{VALUE_WIDTH{1'b0}}, in_tdata};
  assign rd_ext = {32'd0, mem_rdata};

  csort_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  csort_seq #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_value  (in_ext[VALUE_WIDTH-1:0]),
    .in_last   (in_tlast),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .out_free  (out_free),
    .out_ld    (out_ld)
  );

  // Output slot is free when empty or being taken this cycle
  assign out_free = !out_valid_r || out_tready;

  // Output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ld.load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (out_ld.load) begin
      out_value_r <= rd_ext[31:0];
      out_pos_r   <= out_ld.position;
      out_last_r  <= out_ld.last;
      out_cmp_r   <= out_ld.compares;
      out_xch_r   <= out_ld.exchanges;
      out_ovf_r   <= out_ld.overflow;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {3'd0, out_ovf_r, out_xch_r, out_cmp_r, out_pos_r, out_value_r};

endmodule
`default_nettype wire

@@ dv/testbench.sv @@
// Self-checking bench for the cocktail shaker sorter: batches of words in, sorted words out.
module testbench;
  import csort_pkg::*;

  localparam int unsigned SORT_DEPTH  = 64;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned PHASE_WORDS = 20;

  typedef struct {
    logic [31:0] value;
    logic        last;
  } load_word_t;

  typedef struct {
    logic signed [31:0]  value;
    logic [POS_W-1:0]    position;
    logic                final_item;
    logic [COUNT_W-1:0]  compares;
    logic [COUNT_W-1:0]  exchanges;
    logic                overflow;
  } sorted_word_t;

  typedef enum int {
    FILL_RANDOM,
    FILL_DUPES,
    FILL_FALLING
  } fill_mode_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  wire         in_tready;
  logic [31:0] in_tdata   = '0;
  logic        in_tlast   = 1'b0;
  wire         out_tvalid;
  logic        out_tready = 1'b0;
  wire  [63:0] out_tdata;
  wire         out_tlast;

  load_word_t         pending_words[$];
  load_word_t         word_on_bus;
  logic signed [31:0] batch_vals[$];
  logic               batch_dropped = 1'b0;
  sorted_word_t       awaited_sorted[$];

  // Working copy of the batch while the predictor sorts it
  logic signed [31:0] work_vals[SORT_DEPTH];
  logic [COUNT_W-1:0] cmp_tally;
  logic [COUNT_W-1:0] xchg_tally;
  logic               pass_swapped;

  int unsigned send_gap_pct   = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned mismatches     = 0;

  cocktail_shaker_sorter_top #(
    .DEPTH       (SORT_DEPTH),
    .VALUE_WIDTH (32)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Compare one neighbouring pair, swap if out of order, count both events
  function automatic void order_pair(int lo);
    logic signed [31:0] t;
    if (cmp_tally < COUNT_MAX) cmp_tally = cmp_tally + 1'b1;
    if (work_vals[lo] > work_vals[lo + 1]) begin
      t                 = work_vals[lo];
      work_vals[lo]     = work_vals[lo + 1];
      work_vals[lo + 1] = t;
      if (xchg_tally < COUNT_MAX) xchg_tally = xchg_tally + 1'b1;
      pass_swapped = 1'b1;
    end
  endfunction

  // Sort the held batch and queue one sorted word per element
  function automatic void sort_and_predict();
    int           n;
    int           left;
    int           right;
    int           i;
    sorted_word_t w;
    n = batch_vals.size();
    for (i = 0; i < n; i++) work_vals[i] = batch_vals[i];
    cmp_tally  = '0;
    xchg_tally = '0;
    left  = 0;
    right = n - 1;
    do begin
      pass_swapped = 1'b0;
      for (i = left; i < right; i++) order_pair(i);
      right--;
      for (i = right; i > left; i--) order_pair(i - 1);
      left++;
    end while (pass_swapped);
    for (i = 0; i < n; i++) begin
      w.value      = work_vals[i];
      w.position   = i[POS_W-1:0];
      w.final_item = (i == n - 1);
      w.compares   = w.final_item ? cmp_tally : '0;
      w.exchanges  = w.final_item ? xchg_tally : '0;
      w.overflow   = batch_dropped;
      awaited_sorted.push_back(w);
    end
  endfunction

  // Take one accepted word into the batch; drop it once the store is full
  function automatic void absorb_word(load_word_t w);
    if (batch_vals.size() < SORT_DEPTH) batch_vals.push_back(w.value);
    else batch_dropped = 1'b1;
    if (w.last) begin
      sort_and_predict();
      batch_vals.delete();
      batch_dropped = 1'b0;
    end
  endfunction

  function automatic void flag_mismatch(string what, logic [63:0] exp_v, logic [63:0] act_v);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch on %s: expected %h, got %h", what, exp_v, act_v);
  endfunction

  function automatic void check_field(string what, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) flag_mismatch(what, exp_v, act_v);
  endfunction

  // Check one result word against the oldest prediction
  function automatic void check_sorted_word();
    sorted_word_t e;
    if (awaited_sorted.size() == 0) begin
      flag_mismatch("unexpected word", '0, out_tdata);
    end else begin
      e = awaited_sorted.pop_front();
      check_field("sorted_value", e.value[31:0], out_tdata[31:0]);
      check_field("position", e.position, out_tdata[37:32]);
      check_field("compare_count", e.compares, out_tdata[48:38]);
      check_field("exchange_count", e.exchanges, out_tdata[59:49]);
      check_field("overflow", e.overflow, out_tdata[60]);
      check_field("final_item", e.final_item, out_tlast);
    end
  endfunction

  // Driver: predict on acceptance, then offer the next word or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) absorb_word(word_on_bus);
      if (!in_tvalid || in_tready) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          word_on_bus = pending_words.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= word_on_bus.value;
          in_tlast  <= word_on_bus.last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random back-pressure, check every accepted result word
  always @(posedge clk) begin
    out_tready <= rst_n && ($urandom_range(99) >= sink_stall_pct);
    if (rst_n && out_tvalid && out_tready) check_sorted_word();
  end

  task automatic push_word(logic [31:0] value, logic last);
    load_word_t w;
    w.value = value;
    w.last  = last;
    pending_words.push_back(w);
  endtask

  task automatic queue_batch(int len, fill_mode_t mode);
    logic [31:0] v;
    logic [31:0] falling;
    int          i;
    falling = $urandom;
    for (i = 0; i < len; i++) begin
      case (mode)
        FILL_DUPES: begin
          v = $urandom_range(6);
          v = v - 32'd3;
        end
        FILL_FALLING: begin
          v       = falling;
          falling = falling - $urandom_range(1, 5000);
        end
        default: begin
          v = $urandom;
        end
      endcase
      push_word(v, i == len - 1);
    end
  endtask

  // Hold until every queued word is taken and every result has come back
  task automatic drain();
    @(negedge clk);
    while (pending_words.size() != 0 || in_tvalid || awaited_sorted.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    int         phase;
    int         queued;
    int         len;
    fill_mode_t mode;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: lone minimum, extremes, sorted, reversed, duplicates
    push_word(32'h8000_0000, 1'b1);
    push_word(32'h7FFF_FFFF, 1'b0);
    push_word(32'h8000_0000, 1'b0);
    push_word(32'h0000_0000, 1'b0);
    push_word(32'hFFFF_FFFF, 1'b1);
    push_word(32'd1, 1'b0);
    push_word(32'd2, 1'b0);
    push_word(32'd3, 1'b0);
    push_word(32'd4, 1'b1);
    for (int k = 7; k >= 1; k--) push_word(k, k == 1);
    push_word(32'd3, 1'b0);
    push_word(32'd3, 1'b0);
    push_word(-32'sd2, 1'b0);
    push_word(32'd3, 1'b0);
    push_word(-32'sd2, 1'b1);
    drain();

    // Random batches over four back-pressure phases
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_gap_pct = 0;  sink_stall_pct = 0;  end
        1: begin send_gap_pct = 70; sink_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  sink_stall_pct = 70; end
        default: begin send_gap_pct = 12; sink_stall_pct = 12; end
      endcase
      // Overfill the store once, the dropped word carrying the end mark
      if (phase == 0) queue_batch(SORT_DEPTH + 1, FILL_RANDOM);
      queued = 0;
      while (queued < PHASE_WORDS) begin
        len  = ($urandom_range(24) == 0) ? $urandom_range(60, 68) : $urandom_range(1, 10);
        mode = fill_mode_t'($urandom_range(2));
        queue_batch(len, mode);
        queued += len;
      end
      drain();
    end

    repeat (100) @(posedge clk);
    if (mismatches == 0 && awaited_sorted.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Give up if the run hangs
  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
